### sv/mbwd_pkg.sv
// ----------------------------------------------------------------------------
// mbwd_pkg
// shared types and constants of the masked binary window dilation block
// ----------------------------------------------------------------------------
package mbwd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int WIDTH_CFG_W = 11;
    localparam int HEIGHT_CFG_W = 13;
    localparam int HALF_CFG_W  = 3;
    localparam int PIXEL_W     = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF   = 2'd2;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [HALF_CFG_W-1:0]   HALF_RESET   = 3'd4;

    localparam logic [PIXEL_W-1:0] SET_BYTE = 8'd255;

    typedef struct packed {
        logic cfg_we;
        logic px_store;
        logic rd_win;
        logic own_load;
        logic win_start;
        logic win_next;
        logic hit;
        logic out_load;
    } mbwd_cmd_t;

    typedef struct packed {
        logic in_done;
        logic at_delay;
        logic dilate;
        logic set_hit;
        logic win_end;
        logic out_full;
    } mbwd_stat_t;

endpackage

### sv/masked_binary_window_dilation_top.sv
// ----------------------------------------------------------------------------
// masked_binary_window_dilation_top
// masked binary dilation with a square window over a raster pixel stream
//
//   channel   signals                                      direction
//   cfg       cfg_valid cfg_ready cfg_index cfg_data       in
//   in        in_valid in_ready action bin_pixel mask_pixel in
//   out       out_valid out_ready out_pixel out_last       out
//
// a pixel that emits no result is only stored; an emitting item passes the own
// address, own check and output steps, plus an address and a check step per window
// entry scanned for an interior masked pixel (up to (2k+1)^2 entries), as the line store has a single read port
// the scan stops at the first set entry
// reset clears counters and loads default size 640x480, half size 4
// a stalled output holds the block in its output step until the transfer
// ----------------------------------------------------------------------------
module masked_binary_window_dilation_top
    import mbwd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HALF   = 4,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   action,
    input  logic [PIXEL_W-1:0]     bin_pixel,
    input  logic [PIXEL_W-1:0]     mask_pixel,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PIXEL_W-1:0]     out_pixel,
    output logic                   out_last
);

    mbwd_cmd_t  cmd;
    mbwd_stat_t stat;

    mbwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .cfg_valid (cfg_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    mbwd_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HALF   (MAX_HALF),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .bin_pixel  (bin_pixel),
        .mask_pixel (mask_pixel),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_pixel  (out_pixel),
        .out_last   (out_last)
    );

endmodule

### sv/mbwd_ram.sv
// ----------------------------------------------------------------------------
// mbwd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mbwd_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 9216
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/mbwd_datapath.sv
// ----------------------------------------------------------------------------
// mbwd_datapath
// config registers, raster counters, line store and window scan registers
// ----------------------------------------------------------------------------
module mbwd_datapath
    import mbwd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HALF   = 4,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mbwd_cmd_t               cmd,
    output mbwd_stat_t              stat,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic [PIXEL_W-1:0]      bin_pixel,
    input  logic [PIXEL_W-1:0]      mask_pixel,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [PIXEL_W-1:0]      out_pixel,
    output logic                    out_last
);

    localparam int RING  = 2 * MAX_HALF + 1;
    localparam int RGW   = $clog2(RING);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int HW    = $clog2(MAX_HALF + 1);
    localparam int SW    = PIXEL_W + 1;
    localparam int NW    = RW + WW;

    logic [WIDTH_CFG_W-1:0]  width_cfg_reg;
    logic [HEIGHT_CFG_W-1:0] height_cfg_reg;
    logic [HALF_CFG_W-1:0]   half_cfg_reg;

    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [RW-1:0]  in_row_reg, in_row_next;
    logic [RGW-1:0] in_ring_reg, in_ring_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [RW-1:0]  out_row_reg, out_row_next;
    logic [RGW-1:0] out_ring_reg, out_ring_next;

    logic [CW-1:0]  win_col_reg;
    logic [RGW-1:0] win_ring_reg;
    logic [HW:0]    win_dx_reg;
    logic [HW:0]    win_dy_reg;

    logic [PIXEL_W-1:0] res_reg;
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic               out_last_reg;

    logic [WW-1:0]  eff_w;
    logic [RW-1:0]  eff_h;
    logic [HW-1:0]  eff_k;
    logic [HW:0]    two_k;
    logic           cfg_hit;
    logic           in_col_end;
    logic           out_col_end;
    logic           frame_last;
    logic           interior;
    logic [RGW:0]   ring_sum;
    logic [RGW-1:0] win_ring_start;
    logic [CW-1:0]  win_col_start;
    logic [AW-1:0]  waddr;
    logic [AW-1:0]  raddr;
    logic [SW-1:0]  wdata;
    logic [SW-1:0]  rdata;
    logic [NW-1:0]  in_pos;
    logic [NW-1:0]  delay_pos;

    // clamped configuration
    always_comb
    begin
        if (width_cfg_reg == '0)
            eff_w = WW'(1);
        else if (int'(width_cfg_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(width_cfg_reg);

        if (height_cfg_reg == '0)
            eff_h = RW'(1);
        else if (int'(height_cfg_reg) > MAX_HEIGHT)
            eff_h = RW'(MAX_HEIGHT);
        else
            eff_h = RW'(height_cfg_reg);

        if (half_cfg_reg == '0)
            eff_k = HW'(1);
        else if (int'(half_cfg_reg) > MAX_HALF)
            eff_k = HW'(MAX_HALF);
        else
            eff_k = HW'(half_cfg_reg);
    end

    assign two_k = {eff_k, 1'b0};

    assign cfg_hit = (cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT)
                     || (cfg_index == CFG_HALF);

    assign in_col_end  = (WW'(in_col_reg) == eff_w - 1'b1);
    assign out_col_end = (WW'(out_col_reg) == eff_w - 1'b1);
    assign frame_last  = (out_row_reg == eff_h - 1'b1) && out_col_end;

    assign interior = (out_row_reg >= RW'(eff_k))
                      && ((RW+1)'(out_row_reg) + (RW+1)'(eff_k) < (RW+1)'(eff_h))
                      && (out_col_reg >= CW'(eff_k))
                      && ((WW+1)'(out_col_reg) + (WW+1)'(eff_k) < (WW+1)'(eff_w));

    // window start: k rows up and k columns left of the output pixel
    assign ring_sum = (RGW+1)'(out_ring_reg) + (RGW+1)'(RING) - (RGW+1)'(eff_k);
    assign win_ring_start = (ring_sum >= (RGW+1)'(RING)) ?
                            RGW'(ring_sum - (RGW+1)'(RING)) : RGW'(ring_sum);
    assign win_col_start = out_col_reg - CW'(eff_k);

    assign waddr = AW'(in_ring_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign raddr = cmd.rd_win ?
                   AW'(win_ring_reg) * AW'(MAX_WIDTH) + AW'(win_col_reg) :
                   AW'(out_ring_reg) * AW'(MAX_WIDTH) + AW'(out_col_reg);
    assign wdata = {(mask_pixel == SET_BYTE), bin_pixel};

    // raster position of the incoming pixel and the output delay
    assign in_pos    = NW'(in_row_reg) * NW'(eff_w) + NW'(in_col_reg);
    assign delay_pos = NW'(eff_k) * NW'(eff_w) + NW'(eff_k);

    mbwd_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (cmd.px_store),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // raster counters
    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_ring_next  = in_ring_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_ring_next = out_ring_reg;
        if ((cmd.cfg_we && cfg_hit) || (cmd.out_load && frame_last))
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_ring_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_ring_next = '0;
        end
        else
        begin
            if (cmd.px_store)
            begin
                if (in_col_end)
                begin
                    in_col_next  = '0;
                    in_row_next  = in_row_reg + 1'b1;
                    in_ring_next = (in_ring_reg == RGW'(RING - 1)) ? '0 :
                                   in_ring_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                if (out_col_end)
                begin
                    out_col_next  = '0;
                    out_row_next  = out_row_reg + 1'b1;
                    out_ring_next = (out_ring_reg == RGW'(RING - 1)) ? '0 :
                                    out_ring_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
            half_cfg_reg   <= HALF_RESET;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            in_ring_reg    <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_ring_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WIDTH:  width_cfg_reg  <= cfg_data[WIDTH_CFG_W-1:0];
                    CFG_HEIGHT: height_cfg_reg <= cfg_data[HEIGHT_CFG_W-1:0];
                    CFG_HALF:   half_cfg_reg   <= cfg_data[HALF_CFG_W-1:0];
                    default:    ;
                endcase
            end
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_ring_reg  <= in_ring_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_ring_reg <= out_ring_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // window scan and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.own_load)
            res_reg <= rdata[PIXEL_W-1:0];
        else if (cmd.hit)
            res_reg <= SET_BYTE;

        if (cmd.win_start)
        begin
            win_ring_reg <= win_ring_start;
            win_col_reg  <= win_col_start;
            win_dx_reg   <= '0;
            win_dy_reg   <= '0;
        end
        else if (cmd.win_next)
        begin
            if (win_dx_reg == two_k)
            begin
                win_dx_reg   <= '0;
                win_col_reg  <= win_col_start;
                win_dy_reg   <= win_dy_reg + 1'b1;
                win_ring_reg <= (win_ring_reg == RGW'(RING - 1)) ? '0 :
                                win_ring_reg + 1'b1;
            end
            else
            begin
                win_dx_reg  <= win_dx_reg + 1'b1;
                win_col_reg <= win_col_reg + 1'b1;
            end
        end

        if (cmd.out_load)
        begin
            out_pixel_reg <= res_reg;
            out_last_reg  <= frame_last;
        end
    end

    assign stat.in_done  = (in_row_reg >= eff_h);
    assign stat.at_delay = (in_pos >= delay_pos);
    assign stat.dilate   = interior && rdata[PIXEL_W];
    assign stat.set_hit  = (rdata[PIXEL_W-1:0] == SET_BYTE);
    assign stat.win_end  = (win_dx_reg == two_k) && (win_dy_reg == two_k);
    assign stat.out_full = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

### sv/mbwd_ctrl.sv
// ----------------------------------------------------------------------------
// mbwd_ctrl
// sequencer for store, own pixel read, window scan and output load
// ----------------------------------------------------------------------------
module mbwd_ctrl
    import mbwd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       action,
    input  logic       cfg_valid,
    input  logic       out_ready,
    input  mbwd_stat_t stat,
    output logic       in_ready,
    output logic       cfg_ready,
    output mbwd_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_OWN_ADDR = 6'b000010,
        S_OWN_CHK  = 6'b000100,
        S_WIN_ADDR = 6'b001000,
        S_WIN_CHK  = 6'b010000,
        S_OUT      = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.cfg_we = 1'b1;
                end
                else if (in_valid)
                begin
                    if (action)
                    begin
                        if (stat.in_done)
                            state_next = S_OWN_ADDR;
                    end
                    else if (!stat.in_done)
                    begin
                        cmd.px_store = 1'b1;
                        if (stat.at_delay)
                            state_next = S_OWN_ADDR;
                    end
                end
            end
            S_OWN_ADDR:
            begin
                state_next = S_OWN_CHK;
            end
            S_OWN_CHK:
            begin
                cmd.own_load = 1'b1;
                if (stat.dilate)
                begin
                    cmd.win_start = 1'b1;
                    state_next    = S_WIN_ADDR;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_WIN_ADDR:
            begin
                cmd.rd_win = 1'b1;
                state_next = S_WIN_CHK;
            end
            S_WIN_CHK:
            begin
                priority if (stat.set_hit)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_OUT;
                end
                else if (stat.win_end)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.win_next = 1'b1;
                    state_next   = S_WIN_ADDR;
                end
            end
            S_OUT:
            begin
                if (!stat.out_full || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### sv/mbwd_checker.sv
// ----------------------------------------------------------------------------
// mbwd_sva
// port level checks of the dilation block
// ----------------------------------------------------------------------------
module mbwd_sva
    import mbwd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [PIXEL_W-1:0] out_pixel,
    input logic               out_last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_last))
        else $error("stalled output changed");

    // config and pixel transfers never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready && in_valid && in_ready))
        else $error("config and input transfer in one cycle");

    // input is only taken when config could be taken too
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> cfg_ready)
        else $error("input ready while busy");

    // during a config transfer the input is never ready
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !in_ready)
        else $error("input ready during config transfer");

endmodule

bind masked_binary_window_dilation_top mbwd_sva u_mbwd_sva (.*);
